FILE: hw/rtl/lhs_pkg.sv
package lhs_pkg;

	// statistic ids, in readout order
	localparam logic [3:0] STAT_TOTAL     = 4'd0;
	localparam logic [3:0] STAT_OK        = 4'd1;
	localparam logic [3:0] STAT_FAILED    = 4'd2;
	localparam logic [3:0] STAT_BLOCKED   = 4'd3;
	localparam logic [3:0] STAT_RECOVERED = 4'd4;
	localparam logic [3:0] STAT_EXHAUSTED = 4'd5;
	localparam logic [3:0] STAT_MIN       = 4'd6;
	localparam logic [3:0] STAT_MAX       = 4'd7;
	localparam logic [3:0] STAT_AVG       = 4'd8;
	localparam logic [3:0] STAT_P50       = 4'd9;
	localparam logic [3:0] STAT_P90       = 4'd10;
	localparam logic [3:0] STAT_P99       = 4'd11;
	localparam logic [3:0] STAT_HTML      = 4'd12;
	localparam logic [3:0] STAT_MARKDOWN  = 4'd13;
	localparam logic [3:0] STAT_PDF       = 4'd14;
	localparam logic [3:0] STAT_SHOT      = 4'd15;

	// request kinds on tuser
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// percentile ranks in percent, and floor(x/100) = (x*RECIP_100) >> RECIP_SHIFT
	localparam int NUM_PCT = 3;
	localparam logic [6:0] PCT_Q [NUM_PCT] = '{7'd50, 7'd90, 7'd99};
	localparam logic [6:0] PCT_DIV = 7'd100;
	localparam logic [13:0] PCT_ROUND = 14'd99;
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int RECIP_SHIFT = 19;

	// controller to datapath
	typedef struct packed {
		logic rec;
		logic q_start;
		logic sum_step;
		logic div_start;
		logic div_sel;
		logic tgt_a;
		logic tgt_b;
		logic scan_step;
		logic emit_step;
	} lhs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic idx_last;
		logic emit_last;
	} lhs_status_t;

endpackage

FILE: hw/rtl/lhs_div.sv
module lhs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] sh;
	logic        fit;

	// one quotient bit per cycle, restoring
	assign sh  = {rem_q, quo_q[63]};
	assign fit = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? 64'(sh - {1'b0, dvs_q}) : sh[63:0];
			quo_q <= {quo_q[62:0], fit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/lhs_datapath.sv
module lhs_datapath #(
	parameter int BUCKETS    = 32,
	parameter int COUNT_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lhs_pkg::lhs_cmd_t    cmd,
	output lhs_pkg::lhs_status_t status,
	input  logic                 task_ok,
	input  logic [31:0]          elapsed_ms,
	input  logic [3:0]           output_mask,
	input  logic [3:0]           block_hits,
	input  logic                 block_final,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [63:0]          m_tdata,
	output logic [3:0]           m_tuser,
	output logic                 m_tlast
);
	import lhs_pkg::*;

	localparam int IDXW = $clog2(BUCKETS);
	localparam int CW   = COUNT_BITS;

	function automatic logic [CW-1:0] sat_c(input logic [CW-1:0] a, input logic [3:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + (CW+1)'(b);
		return s[CW] ? {CW{1'b1}} : s[CW-1:0];
	endfunction

	function automatic logic [63:0] sat64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	// task counters
	logic [CW-1:0] total_q, ok_q, blk_q, recov_q, exh_q;
	logic [CW-1:0] outc_q [4];
	logic [CW-1:0] bkt_q [BUCKETS];
	logic [63:0]   lsum_q;
	logic [31:0]   lmin_q, lmax_q;

	// query working registers
	logic [IDXW-1:0] idx_q;
	logic [63:0]     n_q, qt_q, avg_q, acc_q;
	logic [6:0]      r_q;
	logic [13:0]     prod_q [NUM_PCT];
	logic [63:0]     tgt_q [NUM_PCT];
	logic            hit_q [NUM_PCT];
	logic [IDXW-1:0] hidx_q [NUM_PCT];
	logic [3:0]      stat_q;

	// byte-wise n/100
	logic [63:0] dq_n_q;
	logic [3:0]  dq_cnt_q;
	logic        dq_busy_q;
	logic        dq_done_q;
	logic [14:0] dq_x;
	logic [27:0] dq_m;
	logic [7:0]  dq_qd;
	logic [6:0]  dq_r;

	// output register
	logic        ovalid_q;
	logic [63:0] odata_q;
	logic [3:0]  ouser_q;
	logic        olast_q;

	logic [4:0]      lg;
	logic [5:0]      lg_cl;
	logic [IDXW-1:0] widx;
	logic            sample;
	logic [63:0]     bkt_rd, acc_nx;
	logic            div_done;
	logic [63:0]     div_quo;
	logic            out_free;
	logic [63:0]     sval;

	// floor log2 of the latency, clamped to the last bucket
	always_comb begin
		lg = '0;
		for (int i = 0; i < 32; i++) begin
			if (elapsed_ms[i]) lg = 5'(i);
		end
		lg_cl = (32'(lg) >= 32'(BUCKETS)) ? 6'(BUCKETS - 1) : {1'b0, lg};
		widx  = IDXW'(lg_cl);
	end

	assign sample = cmd.rec && task_ok && (elapsed_ms != 32'd0);
	assign bkt_rd = 64'(bkt_q[idx_q]);
	assign acc_nx = sat64(acc_q, bkt_rd);

	// record update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ok_q    <= '0;
			blk_q   <= '0;
			recov_q <= '0;
			exh_q   <= '0;
			lsum_q  <= '0;
			lmin_q  <= '0;
			lmax_q  <= '0;
			for (int i = 0; i < 4; i++) outc_q[i] <= '0;
			for (int b = 0; b < BUCKETS; b++) bkt_q[b] <= '0;
		end else if (cmd.rec) begin
			total_q <= sat_c(total_q, 4'd1);
			blk_q   <= sat_c(blk_q, block_hits);
			if (task_ok && block_hits != 4'd0) recov_q <= sat_c(recov_q, 4'd1);
			if (block_final) exh_q <= sat_c(exh_q, 4'd1);
			if (task_ok) ok_q <= sat_c(ok_q, 4'd1);
			for (int i = 0; i < 4; i++) begin
				if (output_mask[i]) outc_q[i] <= sat_c(outc_q[i], 4'd1);
			end
			if (sample) begin
				for (int b = 0; b < BUCKETS; b++) begin
					if (widx == IDXW'(b)) bkt_q[b] <= sat_c(bkt_q[b], 4'd1);
				end
				lsum_q <= sat64(lsum_q, 64'(elapsed_ms));
				if (lmin_q == 32'd0 || elapsed_ms < lmin_q) lmin_q <= elapsed_ms;
				if (elapsed_ms > lmax_q) lmax_q <= elapsed_ms;
			end
		end
	end

	// bit-serial divider for the average sum/n
	lhs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start && cmd.div_sel),
		.dividend (lsum_q),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// rank base n/100 one byte per cycle, top byte first; {remainder, byte}
	// stays below 25600, where the reciprocal multiply is exact
	assign dq_x  = {r_q, dq_n_q[63:56]};
	assign dq_m  = 28'(dq_x) * 28'(RECIP_100);
	assign dq_qd = 8'(dq_m >> RECIP_SHIFT);
	assign dq_r  = 7'(dq_x - 15'(dq_qd * PCT_DIV));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_busy_q <= 1'b0;
			dq_done_q <= 1'b0;
			dq_cnt_q  <= '0;
		end else begin
			dq_done_q <= 1'b0;
			if (cmd.div_start && !cmd.div_sel) begin
				dq_busy_q <= 1'b1;
				dq_cnt_q  <= 4'd8;
			end else if (dq_busy_q) begin
				dq_cnt_q <= dq_cnt_q - 4'd1;
				if (dq_cnt_q == 4'd1) begin
					dq_busy_q <= 1'b0;
					dq_done_q <= 1'b1;
				end
			end
		end
	end

	// query sequencing registers
	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			n_q   <= '0;
			idx_q <= '0;
		end
		if (cmd.sum_step) begin
			n_q   <= sat64(n_q, bkt_rd);
			idx_q <= IDXW'(idx_q + 1'b1);
		end
		if (div_done) avg_q <= div_quo;
		if (cmd.div_start && !cmd.div_sel) begin
			dq_n_q <= n_q;
			qt_q   <= '0;
			r_q    <= '0;
		end else if (dq_busy_q) begin
			dq_n_q <= {dq_n_q[55:0], 8'd0};
			qt_q   <= {qt_q[55:0], dq_qd};
			r_q    <= dq_r;
		end
		if (cmd.tgt_a) begin
			for (int k = 0; k < NUM_PCT; k++) prod_q[k] <= 14'(r_q * PCT_Q[k]);
		end
		if (cmd.tgt_b) begin
			for (int k = 0; k < NUM_PCT; k++) begin
				logic [26:0] cm;
				logic [70:0] mq;
				logic [63:0] t;
				cm = 27'(prod_q[k] + PCT_ROUND) * 27'(RECIP_100);
				mq = 71'(qt_q) * 71'(PCT_Q[k]);
				t  = mq[63:0] + 64'(cm[26:RECIP_SHIFT]);
				tgt_q[k] <= (t == 64'd0) ? 64'd1 : t;
				hit_q[k] <= 1'b0;
			end
			acc_q <= '0;
			idx_q <= '0;
		end
		// running count against all three ranks at once
		if (cmd.scan_step) begin
			acc_q <= acc_nx;
			for (int k = 0; k < NUM_PCT; k++) begin
				if (!hit_q[k] && acc_nx >= tgt_q[k]) begin
					hit_q[k]  <= 1'b1;
					hidx_q[k] <= idx_q;
				end
			end
			idx_q <= IDXW'(idx_q + 1'b1);
		end
	end

	// midpoint of the bucket that reached the rank, or the maximum latency if none did
	function automatic logic [63:0] pct_val(input logic hit, input logic [IDXW-1:0] i,
			input logic [31:0] mx);
		logic [63:0] lo, hi;
		logic [64:0] s;
		if (!hit) return 64'(mx);
		lo = (i == '0) ? 64'd1 : (64'd1 << i);
		hi = (i == IDXW'(BUCKETS - 1)) ? 64'(mx) : (64'd1 << (7'(i) + 7'd1));
		if (hi <= lo) hi = lo + 64'd1;
		s = {1'b0, lo} + {1'b0, hi};
		return s[64:1];
	endfunction

	// statistic select
	always_comb begin
		logic has;
		has = n_q != 64'd0;
		unique case (stat_q)
			STAT_TOTAL:     sval = 64'(total_q);
			STAT_OK:        sval = 64'(ok_q);
			STAT_FAILED:    sval = (total_q >= ok_q) ? 64'(total_q - ok_q) : 64'd0;
			STAT_BLOCKED:   sval = 64'(blk_q);
			STAT_RECOVERED: sval = 64'(recov_q);
			STAT_EXHAUSTED: sval = 64'(exh_q);
			STAT_MIN:       sval = has ? 64'(lmin_q) : 64'd0;
			STAT_MAX:       sval = has ? 64'(lmax_q) : 64'd0;
			STAT_AVG:       sval = has ? avg_q : 64'd0;
			STAT_P50:       sval = has ? pct_val(hit_q[0], hidx_q[0], lmax_q) : 64'd0;
			STAT_P90:       sval = has ? pct_val(hit_q[1], hidx_q[1], lmax_q) : 64'd0;
			STAT_P99:       sval = has ? pct_val(hit_q[2], hidx_q[2], lmax_q) : 64'd0;
			STAT_HTML:      sval = 64'(outc_q[0]);
			STAT_MARKDOWN:  sval = 64'(outc_q[1]);
			STAT_PDF:       sval = 64'(outc_q[2]);
			STAT_SHOT:      sval = 64'(outc_q[3]);
			default:        sval = 64'd0;
		endcase
	end

	assign out_free = !ovalid_q || m_tready;

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			stat_q   <= '0;
		end else begin
			if (cmd.q_start) stat_q <= STAT_TOTAL;
			if (cmd.emit_step && out_free) begin
				ovalid_q <= 1'b1;
				stat_q   <= stat_q + 4'd1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step && out_free) begin
			odata_q <= sval;
			ouser_q <= stat_q;
			olast_q <= stat_q == STAT_SHOT;
		end
	end

	assign status.div_done  = div_done || dq_done_q;
	assign status.idx_last  = idx_q == IDXW'(BUCKETS - 1);
	assign status.emit_last = cmd.emit_step && out_free && (stat_q == STAT_SHOT);

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;
	assign m_tlast  = olast_q;

endmodule

FILE: hw/rtl/lhs_ctrl.sv
module lhs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 op,
	output logic                 s_tready,
	input  lhs_pkg::lhs_status_t status,
	output lhs_pkg::lhs_cmd_t    cmd
);
	import lhs_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SUM  = 10'b0000000010,
		S_DQ   = 10'b0000000100,
		S_DQW  = 10'b0000001000,
		S_TA   = 10'b0000010000,
		S_TB   = 10'b0000100000,
		S_SCAN = 10'b0001000000,
		S_DA   = 10'b0010000000,
		S_DAW  = 10'b0100000000,
		S_EMIT = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (op == OP_QUERY) begin
						cmd.q_start = 1'b1;
						state_d     = S_SUM;
					end else begin
						cmd.rec = 1'b1;
					end
				end
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (status.idx_last) state_d = S_DQ;
			end
			S_DQ: begin
				cmd.div_start = 1'b1;
				state_d       = S_DQW;
			end
			S_DQW: begin
				if (status.div_done) state_d = S_TA;
			end
			S_TA: begin
				cmd.tgt_a = 1'b1;
				state_d   = S_TB;
			end
			S_TB: begin
				cmd.tgt_b = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.idx_last) state_d = S_DA;
			end
			S_DA: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = S_DAW;
			end
			S_DAW: begin
				cmd.div_sel = 1'b1;
				if (status.div_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit_step = 1'b1;
				if (status.emit_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/latency_histogram_stats_counter_core.sv
// Task statistics with a log2 latency histogram. A record request (tuser op 0)
// updates the counters that apply to it in its accept cycle and yields no
// result; the block is ready again in the next cycle. A query request (tuser
// op 1) yields 16 results, stat_id 0 to 15, the last marked by tlast. Before
// its first result a query occupies the block with a pass over the bucket
// counters for the sample total, a byte-wise rank base n/100, the percentile
// scan over the buckets and a bit-serial 64-bit divide for the average,
// followed by readout through the output register.
module latency_histogram_stats_counter_core #(
	parameter int BUCKETS    = 32,
	parameter int COUNT_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] task_ok, [32:1] elapsed_ms, [36:33] output_mask, [40:37] block_hits,
	// [41] block_final, [47:42] zero
	input  logic [47:0] s_tdata,
	// [0] op
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [63:0] stat_value
	output logic [63:0] m_tdata,
	// [3:0] stat_id
	output logic [3:0]  m_tuser,
	output logic        m_tlast
);
	import lhs_pkg::*;

	lhs_cmd_t    cmd;
	lhs_status_t status;

	lhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser[0]),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lhs_datapath #(
		.BUCKETS    (BUCKETS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.task_ok     (s_tdata[0]),
		.elapsed_ms  (s_tdata[32:1]),
		.output_mask (s_tdata[36:33]),
		.block_hits  (s_tdata[40:37]),
		.block_final (s_tdata[41]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	// tlast marks exactly the final statistic
	a_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == STAT_SHOT)))
		else $error("tlast does not match final stat id");

	// a query request makes the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == OP_QUERY) |=> !s_tready)
		else $error("ready after query request");

	// a record request leaves the block ready
	a_record_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == OP_RECORD) |=> s_tready)
		else $error("not ready after record request");

endmodule
